>>> hw/rtl/black_border_autocrop_assert.svh
// Assertion macros for the black border autocrop checker.
// Depends on nothing; include it from files that hold concurrent assertions.
`ifndef BLACK_BORDER_AUTOCROP_ASSERT_SVH
`define BLACK_BORDER_AUTOCROP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BBAC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BBAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/bbac_pkg.sv
// Shared types, constants and helpers of the black border autocrop block.
// Depends on nothing; every design module and interface imports it, the checker does not.
`default_nettype none

package bbac_pkg;

    localparam int PIX_W     = 8;
    localparam int CFG_W     = 10;
    localparam int THR_W     = 20;
    localparam int CROP_XY_W = 9;
    localparam int CROP_WH_W = 10;
    localparam int CFG_IDX_W = 2;
    localparam int JOB_DEPTH = 2;
    localparam int NUM_SIDES = 4;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd2;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 10'd512;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 10'd512;
    localparam logic [THR_W-1:0] THRESHOLD_RST    = 20'd1000;
    localparam logic [THR_W-1:0] PPM_SCALE        = 20'd1000000;

    typedef struct packed {
        logic [CFG_W-1:0] frame_width;
        logic [CFG_W-1:0] frame_height;
        logic [THR_W-1:0] threshold_ppm;
    } t_job;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CHECK,
        BK_SCAN,
        BK_DRAIN,
        BK_UPDATE,
        BK_REPORT
    } t_back_state;

    typedef enum logic [1:0] {
        SIDE_TOP,
        SIDE_RIGHT,
        SIDE_BOTTOM,
        SIDE_LEFT
    } t_side;

    // Clamp a frame dimension to 1..max_v; the result never exceeds max_v, and a zero input gives 1.
    function automatic logic [CFG_W-1:0] sat_dim(input logic [CFG_W-1:0] v,
                                                 input int unsigned max_v);
        if (v == '0) begin
            return CFG_W'(1);
        end
        if (32'(v) > max_v) begin
            return CFG_W'(max_v);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bbac_if.sv
// Stream interfaces of the black border autocrop block: pixels in, crop result out.
// Depends on bbac_pkg for field widths.
`default_nettype none

interface bbac_pix_if import bbac_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             last_pixel;

    modport source (output valid, output pixel, output last_pixel, input ready);
    modport sink   (input valid, input pixel, input last_pixel, output ready);
endinterface

interface bbac_res_if import bbac_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 found;
    logic [CROP_XY_W-1:0] crop_x;
    logic [CROP_XY_W-1:0] crop_y;
    logic [CROP_WH_W-1:0] crop_width;
    logic [CROP_WH_W-1:0] crop_height;

    modport source (output valid, output found, output crop_x, output crop_y,
                    output crop_width, output crop_height, input ready);
    modport sink   (input valid, input found, input crop_x, input crop_y,
                    input crop_width, input crop_height, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bbac_job_fifo.sv
// Short queue of search jobs between the pixel front end and the search engine.
// Depends on bbac_pkg for the job type and depth.
`default_nettype none

module bbac_job_fifo import bbac_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_ready,
    output logic o_valid,
    output t_job o_data,
    input  logic i_pop
);

    localparam int PTR_W = $clog2(JOB_DEPTH);
    localparam int CNT_W = $clog2(JOB_DEPTH + 1);

    t_job             r_mem [JOB_DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_count != CNT_W'(JOB_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (do_push) begin
            n_wp = (r_wp == PTR_W'(JOB_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == PTR_W'(JOB_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/bbac_front.sv
// Pixel front end: takes pixels, marks zero pixels into the map, queues a search job.
// Depends on bbac_pkg and bbac_if; feeds bbac_job_fifo and the map in bbac_back.
`default_nettype none

module bbac_front import bbac_pkg::*; #(
    parameter  int MAX_WIDTH  = 512,
    parameter  int MAX_HEIGHT = 512,
    localparam int AW         = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bbac_pix_if.sink         i_pix,
    input  logic [CFG_W-1:0] i_frame_width,
    input  logic [CFG_W-1:0] i_frame_height,
    input  logic [THR_W-1:0] i_threshold_ppm,
    output logic             o_job_valid,
    output t_job             o_job,
    input  logic             i_job_ready,
    output logic             o_wr_en,
    output logic [AW-1:0]    o_wr_addr,
    output logic             o_wr_zero,
    input  logic             i_done
);

    localparam int DIM_W = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);

    logic [DIM_W-1:0] fw;
    logic [DIM_W-1:0] fh;
    logic [DIM_W-1:0] r_col, n_col;
    logic [DIM_W-1:0] r_row, n_row;
    logic [AW-1:0]    r_waddr, n_waddr;
    logic             r_busy, n_busy;
    logic             accept;
    logic             in_frame;

    assign fw = DIM_W'(sat_dim(i_frame_width, MAX_WIDTH));
    assign fh = DIM_W'(sat_dim(i_frame_height, MAX_HEIGHT));

    // Hold off the next frame until the search over this map has finished.
    assign i_pix.ready = !r_busy && i_job_ready;
    assign accept      = i_pix.valid && i_pix.ready;
    assign in_frame    = (r_row < fh);

    assign o_wr_en     = accept && in_frame;
    assign o_wr_addr   = r_waddr;
    assign o_wr_zero   = (i_pix.pixel == '0);
    assign o_job_valid = accept && i_pix.last_pixel;
    assign o_job       = '{frame_width:   i_frame_width,
                           frame_height:  i_frame_height,
                           threshold_ppm: i_threshold_ppm};

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_waddr = r_waddr;
        n_busy  = r_busy;
        if (accept) begin
            if (in_frame) begin
                n_waddr = r_waddr + 1'b1;
                if (r_col == fw - 1'b1) begin
                    n_col = '0;
                    n_row = r_row + 1'b1;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            if (i_pix.last_pixel) begin
                n_col   = '0;
                n_row   = '0;
                n_waddr = '0;
                n_busy  = 1'b1;
            end
        end else if (i_done) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_waddr <= '0;
            r_busy  <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_waddr <= n_waddr;
            r_busy  <= n_busy;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/bbac_back.sv
// Search engine: holds the zero map and shrinks the rectangle until its border is clean or it is empty.
// Depends on bbac_pkg and bbac_if; takes jobs from bbac_job_fifo and writes from bbac_front.
`default_nettype none

module bbac_back import bbac_pkg::*; #(
    parameter  int MAX_WIDTH  = 512,
    parameter  int MAX_HEIGHT = 512,
    localparam int AW         = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  t_job          i_job,
    output logic          o_job_pop,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic          i_wr_zero,
    output logic          o_done,
    bbac_res_if.source    o_res
);

    localparam int MAP_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int DIM_W     = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);
    localparam int SW        = DIM_W + 1;
    localparam int PW        = DIM_W + THR_W;
    localparam int NV_W      = $clog2(NUM_SIDES + 1);

    logic r_map [MAP_DEPTH];

    t_back_state          r_state, n_state;
    logic [DIM_W-1:0]     r_fw, n_fw;
    logic [THR_W-1:0]     r_thr, n_thr;
    logic [DIM_W-1:0]     r_x, n_x;
    logic [DIM_W-1:0]     r_y, n_y;
    logic [SW-1:0]        r_w, n_w;
    logic [SW-1:0]        r_h, n_h;
    logic [AW-1:0]        r_base, n_base;
    logic [AW-1:0]        r_addr, n_addr;
    t_side                r_seg, n_seg;
    logic [DIM_W-1:0]     r_k, n_k;
    logic                 r_found, n_found;

    // read / count / multiply / compare pipeline
    logic                 r_rd_valid;
    logic                 r_rd_last;
    t_side                r_rd_seg;
    logic                 r_rd_bit;
    logic [DIM_W-1:0]     r_cnt;
    logic                 r_a_valid;
    t_side                r_a_seg;
    logic [DIM_W-1:0]     r_a_cnt;
    logic [DIM_W-1:0]     r_a_len;
    logic                 r_b_valid;
    t_side                r_b_seg;
    logic [PW-1:0]        r_b_pz;
    logic [PW-1:0]        r_b_pl;
    logic [NUM_SIDES-1:0] r_fail;
    logic [NV_W-1:0]      r_nverd;

    logic                 r_out_valid, n_out_valid;
    logic                 r_out_found;
    logic [CROP_XY_W-1:0] r_out_x;
    logic [CROP_XY_W-1:0] r_out_y;
    logic [CROP_WH_W-1:0] r_out_w;
    logic [CROP_WH_W-1:0] r_out_h;
    logic                 out_load;

    logic [AW-1:0]        fw_ext;
    logic [DIM_W-1:0]     seg_len;
    logic                 seg_last;
    logic [DIM_W-1:0]     cnt_sum;
    logic [DIM_W-1:0]     rd_len;
    logic                 left_bad, top_bad, right_bad, bottom_bad;

    assign fw_ext   = AW'(r_fw);
    assign seg_len  = (r_seg inside {SIDE_TOP, SIDE_BOTTOM}) ? r_w[DIM_W-1:0] : r_h[DIM_W-1:0];
    assign seg_last = (r_k == seg_len - 1'b1);
    assign cnt_sum  = r_cnt + DIM_W'(r_rd_bit);
    assign rd_len   = (r_rd_seg inside {SIDE_TOP, SIDE_BOTTOM}) ? r_w[DIM_W-1:0]
                                                               : r_h[DIM_W-1:0];

    assign left_bad   = r_fail[SIDE_LEFT];
    assign top_bad    = r_fail[SIDE_TOP];
    assign right_bad  = r_fail[SIDE_RIGHT];
    assign bottom_bad = r_fail[SIDE_BOTTOM];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_map[i_wr_addr] <= i_wr_zero;
        end
        r_rd_bit <= r_map[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_fw        = r_fw;
        n_thr       = r_thr;
        n_x         = r_x;
        n_y         = r_y;
        n_w         = r_w;
        n_h         = r_h;
        n_base      = r_base;
        n_addr      = r_addr;
        n_seg       = r_seg;
        n_k         = r_k;
        n_found     = r_found;
        o_job_pop   = 1'b0;
        out_load    = 1'b0;
        n_out_valid = r_out_valid && !o_res.ready;
        case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_fw      = DIM_W'(sat_dim(i_job.frame_width, MAX_WIDTH));
                    n_thr     = i_job.threshold_ppm;
                    n_x       = '0;
                    n_y       = '0;
                    n_w       = SW'(sat_dim(i_job.frame_width, MAX_WIDTH));
                    n_h       = SW'(sat_dim(i_job.frame_height, MAX_HEIGHT));
                    n_base    = '0;
                    n_state   = BK_CHECK;
                end
            end
            BK_CHECK: begin
                // a width or height at zero or below ends the search as a failure
                if (r_w[SW-1] || (r_w == '0) || r_h[SW-1] || (r_h == '0)) begin
                    n_found = 1'b0;
                    n_state = BK_REPORT;
                end else begin
                    n_addr  = r_base;
                    n_seg   = SIDE_TOP;
                    n_k     = '0;
                    n_state = BK_SCAN;
                end
            end
            BK_SCAN: begin
                // walk the border clockwise; each side starts on the previous corner
                if (seg_last) begin
                    n_k = '0;
                    case (r_seg)
                        SIDE_TOP:    n_seg = SIDE_RIGHT;
                        SIDE_RIGHT:  n_seg = SIDE_BOTTOM;
                        SIDE_BOTTOM: n_seg = SIDE_LEFT;
                        default:     n_state = BK_DRAIN;
                    endcase
                end else begin
                    n_k = r_k + 1'b1;
                    case (r_seg)
                        SIDE_TOP:    n_addr = r_addr + 1'b1;
                        SIDE_RIGHT:  n_addr = r_addr + fw_ext;
                        SIDE_BOTTOM: n_addr = r_addr - 1'b1;
                        default:     n_addr = r_addr - fw_ext;
                    endcase
                end
            end
            BK_DRAIN: begin
                if (r_nverd == NV_W'(NUM_SIDES)) begin
                    n_state = BK_UPDATE;
                end
            end
            BK_UPDATE: begin
                if (r_fail == '0) begin
                    n_found = 1'b1;
                    n_state = BK_REPORT;
                end else begin
                    n_x     = r_x + DIM_W'(left_bad);
                    n_y     = r_y + DIM_W'(top_bad);
                    n_w     = r_w - SW'(left_bad) - SW'(right_bad);
                    n_h     = r_h - SW'(top_bad) - SW'(bottom_bad);
                    n_base  = r_base + AW'(left_bad) + (top_bad ? fw_ext : '0);
                    n_state = BK_CHECK;
                end
            end
            BK_REPORT: begin
                if (!r_out_valid || o_res.ready) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    assign o_done = out_load;

    always_ff @(posedge i_clk) begin
        r_fw    <= n_fw;
        r_thr   <= n_thr;
        r_x     <= n_x;
        r_y     <= n_y;
        r_w     <= n_w;
        r_h     <= n_h;
        r_base  <= n_base;
        r_addr  <= n_addr;
        r_seg   <= n_seg;
        r_k     <= n_k;
        r_found <= n_found;
        if (out_load) begin
            r_out_found <= r_found;
            r_out_x     <= r_found ? CROP_XY_W'(r_x) : '0;
            r_out_y     <= r_found ? CROP_XY_W'(r_y) : '0;
            r_out_w     <= r_found ? CROP_WH_W'(r_w) : '0;
            r_out_h     <= r_found ? CROP_WH_W'(r_h) : '0;
        end
    end

    // count zeros per side, then scale both sides of the ppm compare, then compare
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid  <= 1'b0;
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_cnt       <= '0;
            r_nverd     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_valid  <= (r_state == BK_SCAN);
            r_a_valid   <= r_rd_valid && r_rd_last;
            r_b_valid   <= r_a_valid;
            r_out_valid <= n_out_valid;
            if (r_rd_valid) begin
                r_cnt <= r_rd_last ? '0 : cnt_sum;
            end
            if (r_state == BK_CHECK) begin
                r_nverd <= '0;
            end else if (r_b_valid) begin
                r_nverd <= r_nverd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_last <= seg_last;
        r_rd_seg  <= r_seg;
        if (r_rd_valid && r_rd_last) begin
            r_a_seg <= r_rd_seg;
            r_a_cnt <= cnt_sum;
            r_a_len <= rd_len;
        end
        if (r_a_valid) begin
            r_b_seg <= r_a_seg;
            r_b_pz  <= PW'(r_a_cnt) * PW'(PPM_SCALE);
            r_b_pl  <= PW'(r_a_len) * PW'(r_thr);
        end
        if (r_b_valid) begin
            r_fail[r_b_seg] <= (r_b_pz > r_b_pl);
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.found       = r_out_found;
    assign o_res.crop_x      = r_out_x;
    assign o_res.crop_y      = r_out_y;
    assign o_res.crop_width  = r_out_w;
    assign o_res.crop_height = r_out_h;

endmodule

`default_nettype wire

>>> hw/rtl/black_border_autocrop.sv
// Pixels: one transaction per cycle while a frame streams in; the last pixel holds off input.
// Search: the job is queued on the last pixel and popped by the idle engine; each round reads one map
// bit per cycle from the zero map's single read port, then drains (a failing size check goes to report).
// A report cycle after the final round loads the output register, waiting while an earlier
// result is held; input is ready again once the result is registered, even while it waits.
// Reset (i_rst_n, synchronous, active low) clears control and restores the register defaults.
`default_nettype none

module black_border_autocrop import bbac_pkg::*; #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bbac_pix_if.sink             i_pix,
    bbac_res_if.source           o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [THR_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

    // Configuration registers; the user must write them only while no frame is in flight (not enforced).
    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic [THR_W-1:0] r_threshold_ppm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= FRAME_WIDTH_RST;
            r_frame_height  <= FRAME_HEIGHT_RST;
            r_threshold_ppm <= THRESHOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width   <= i_cfg_data[CFG_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height  <= i_cfg_data[CFG_W-1:0];
                REG_THRESHOLD:    r_threshold_ppm <= i_cfg_data;
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    // Front end -> job queue
    logic          push_valid;
    t_job          push_job;
    logic          push_ready;

    // Job queue -> search engine
    logic          job_valid;
    t_job          job;
    logic          job_pop;

    // Map write port and search completion
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          wr_zero;
    logic          search_done;

    // Front: mark zero pixels in raster order and queue a job on the last pixel.
    bbac_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pix           (i_pix),
        .i_frame_width   (r_frame_width),
        .i_frame_height  (r_frame_height),
        .i_threshold_ppm (r_threshold_ppm),
        .o_job_valid     (push_valid),
        .o_job           (push_job),
        .i_job_ready     (push_ready),
        .o_wr_en         (wr_en),
        .o_wr_addr       (wr_addr),
        .o_wr_zero       (wr_zero),
        .i_done          (search_done)
    );

    // Queue: snapshot of the frame size and threshold the search should use.
    bbac_job_fifo u_job_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_valid),
        .i_data  (push_job),
        .o_ready (push_ready),
        .o_valid (job_valid),
        .o_data  (job),
        .i_pop   (job_pop)
    );

    // Back: shrink the rectangle round by round and register the result.
    bbac_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_zero   (wr_zero),
        .o_done      (search_done),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

>>> hw/rtl/bbac_checker.sv
// Port-level checks of the black border autocrop block, bound to its top level.
// Depends on black_border_autocrop_assert.svh for the assertion macros.
`default_nettype none
`include "black_border_autocrop_assert.svh"

module bbac_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_pix_valid,
    input logic       i_pix_ready,
    input logic       i_pix_last_pixel,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic       i_res_found,
    input logic [8:0] i_res_crop_x,
    input logic [8:0] i_res_crop_y,
    input logic [9:0] i_res_crop_width,
    input logic [9:0] i_res_crop_height
);

    // A stalled result stays valid and holds its found flag, x offset and width.
    `BBAC_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_found) && $stable(i_res_crop_x) && $stable(i_res_crop_width), "stalled result changed")

    // A failed search reports an all-zero rectangle.
    `BBAC_ASSERT_SAME(a_fail_zero, i_clk, i_rst_n, i_res_valid && !i_res_found, (i_res_crop_x == '0) && (i_res_crop_y == '0) && (i_res_crop_width == '0) && (i_res_crop_height == '0), "failure with nonzero rectangle")

    // A found rectangle is never empty.
    `BBAC_ASSERT_SAME(a_found_size, i_clk, i_rst_n, i_res_valid && i_res_found, (i_res_crop_width != '0) && (i_res_crop_height != '0), "found rectangle is empty")

    // The last pixel of a frame holds off input right after it is taken.
    `BBAC_ASSERT_NEXT(a_last_stall, i_clk, i_rst_n, i_pix_valid && i_pix_ready && i_pix_last_pixel, !i_pix_ready, "input ready right after last pixel")

endmodule

bind black_border_autocrop bbac_checker u_bbac_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_pix_valid       (i_pix.valid),
    .i_pix_ready       (i_pix.ready),
    .i_pix_last_pixel  (i_pix.last_pixel),
    .i_res_valid       (o_res.valid),
    .i_res_ready       (o_res.ready),
    .i_res_found       (o_res.found),
    .i_res_crop_x      (o_res.crop_x),
    .i_res_crop_y      (o_res.crop_y),
    .i_res_crop_width  (o_res.crop_width),
    .i_res_crop_height (o_res.crop_height)
);

`default_nettype wire
